### rtl/ccfr_pkg.sv
// shared types and constants for the crlf frame receiver
`timescale 1ns / 1ps
`default_nettype none
package ccfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 64;
  localparam int unsigned MIN_FRAME        = 4;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic STREAM_ACK = 1'b0;
  localparam logic STREAM_PAY = 1'b1;

  typedef enum logic [1:0] {
    ACK_MSG   = 2'd0,
    ACK_SUM   = 2'd1,
    ACK_CR    = 2'd2,
    ACK_LF    = 2'd3
  } ack_beat_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_CHECK = 6'b000100,
    S_ACK   = 6'b001000,
    S_PRD   = 6'b010000,
    S_PWR   = 6'b100000
  } state_t;

  typedef struct packed {
    logic       stream;
    logic [7:0] data;
    logic       last;
  } beat_t;

endpackage
`default_nettype wire

### rtl/checksum_crlf_frame_receiver.sv
// top level: crlf frame receiver with output register
// a byte that does not close a frame is accepted while idle; ready again next cycle
// a closing lf runs a checksum pass over the payload via the store read port,
//   a check state, 4 ack beats if connected, then payload beats if not held
// every result beat passes through the output register
// synchronous active-low reset clears control state; the store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module checksum_crlf_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = ccfr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,   // connected
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,      // rx_byte
  input  wire logic       in_tuser,      // cmd
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,     // out_byte
  output logic            out_tuser,     // stream
  output logic            out_tlast
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic            beat_valid;
  logic            beat_ready;
  ccfr_pkg::beat_t beat;
  ccfr_pkg::beat_t out_r;
  logic            out_valid_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_rdata;

  ccfr_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_byte     (in_tdata),
    .o_valid     (beat_valid),
    .o_ready     (beat_ready),
    .o_beat      (beat),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  ccfr_store #(
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign beat_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_ready) begin
      out_valid_r <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      out_r <= beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.stream;
  assign out_tlast  = out_r.last;

endmodule
`default_nettype wire

### rtl/ccfr_store.sv
// frame store: single write port, single registered read port
`timescale 1ns / 1ps
`default_nettype none
module ccfr_store #(
  parameter int unsigned DEPTH = ccfr_pkg::BUFFER_BYTES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/ccfr_ctrl.sv
// frame sequencer with checksum adder, ack and payload emission
`timescale 1ns / 1ps
`default_nettype none
module ccfr_ctrl #(
  parameter int unsigned BUFFER_BYTES = ccfr_pkg::BUFFER_BYTES_DEF,
  localparam int unsigned AW          = $clog2(BUFFER_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_cmd,
  input  wire logic [7:0]    in_byte,
  output logic               o_valid,
  input  wire logic          o_ready,
  output ccfr_pkg::beat_t    o_beat,
  output logic               mem_we,
  output logic      [AW-1:0] mem_waddr,
  output logic      [7:0]    mem_wdata,
  output logic               mem_re,
  output logic      [AW-1:0] mem_raddr,
  input  wire logic [7:0]    mem_rdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_BYTES - 1);
  localparam logic [AW-1:0] MIN_IDX  = AW'(ccfr_pkg::MIN_FRAME - 1);

  ccfr_pkg::state_t    state_r, state_nxt;
  ccfr_pkg::ack_beat_t ack_r, ack_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic          held_r, held_nxt;
  logic          conn_r;
  logic          rv_r, rv_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    prev2_r, prev2_nxt;
  logic [7:0]    chk_r, chk_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [AW-1:0] cnt;

  assign cnt = in_frame_r ? count_r : '0;

  always_comb begin
    state_nxt    = state_r;
    ack_nxt      = ack_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    in_frame_nxt = in_frame_r;
    held_nxt     = held_r;
    rv_nxt       = 1'b0;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    prev2_nxt    = prev2_r;
    chk_nxt      = chk_r;
    sum_nxt      = sum_r;
    in_ready     = 1'b0;
    o_valid      = 1'b0;
    o_beat       = '{stream: ccfr_pkg::STREAM_ACK, data: first_r, last: 1'b0};
    mem_we       = 1'b0;
    mem_waddr    = cnt;
    mem_wdata    = in_byte;
    mem_re       = 1'b0;
    mem_raddr    = idx_r;

    unique case (state_r)
      ccfr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == ccfr_pkg::CMD_RELEASE) begin
            held_nxt = 1'b0;
          end else if (cnt == LAST_IDX) begin
            in_frame_nxt = 1'b0;
            count_nxt    = '0;
          end else begin
            mem_we    = 1'b1;
            prev2_nxt = prev_r;
            prev_nxt  = in_byte;
            if (cnt == '0) begin
              first_nxt = in_byte;
            end
            if (cnt >= MIN_IDX && prev_r == ccfr_pkg::CR_BYTE &&
                in_byte == ccfr_pkg::LF_BYTE) begin
              in_frame_nxt = 1'b0;
              count_nxt    = '0;
              len_nxt      = cnt - AW'(2);
              chk_nxt      = prev2_r;
              idx_nxt      = '0;
              sum_nxt      = '0;
              state_nxt    = ccfr_pkg::S_SUM;
            end else begin
              in_frame_nxt = 1'b1;
              count_nxt    = cnt + AW'(1);
            end
          end
        end
      end
      ccfr_pkg::S_SUM: begin
        if (idx_r != len_r) begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + AW'(1);
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          sum_nxt = sum_r + mem_rdata;
        end
        if (idx_r == len_r && !rv_r) begin
          state_nxt = ccfr_pkg::S_CHECK;
        end
      end
      ccfr_pkg::S_CHECK: begin
        idx_nxt = '0;
        ack_nxt = ccfr_pkg::ACK_MSG;
        if (sum_r != chk_r) begin
          state_nxt = ccfr_pkg::S_IDLE;
        end else if (conn_r) begin
          state_nxt = ccfr_pkg::S_ACK;
        end else if (!held_r) begin
          held_nxt  = 1'b1;
          state_nxt = ccfr_pkg::S_PRD;
        end else begin
          state_nxt = ccfr_pkg::S_IDLE;
        end
      end
      ccfr_pkg::S_ACK: begin
        o_valid = 1'b1;
        unique case (ack_r)
          ccfr_pkg::ACK_CR: o_beat.data = ccfr_pkg::CR_BYTE;
          ccfr_pkg::ACK_LF: o_beat.data = ccfr_pkg::LF_BYTE;
          default:          o_beat.data = first_r;
        endcase
        o_beat.last = (ack_r == ccfr_pkg::ACK_LF) && held_r;
        if (o_ready) begin
          ack_nxt = ccfr_pkg::ack_beat_t'(ack_r + 2'd1);
          if (ack_r == ccfr_pkg::ACK_LF) begin
            if (!held_r) begin
              held_nxt  = 1'b1;
              state_nxt = ccfr_pkg::S_PRD;
            end else begin
              state_nxt = ccfr_pkg::S_IDLE;
            end
          end
        end
      end
      ccfr_pkg::S_PRD: begin
        mem_re    = 1'b1;
        state_nxt = ccfr_pkg::S_PWR;
      end
      ccfr_pkg::S_PWR: begin
        o_valid       = 1'b1;
        o_beat.stream = ccfr_pkg::STREAM_PAY;
        o_beat.data   = mem_rdata;
        o_beat.last   = (idx_r == len_r - AW'(1));
        if (o_ready) begin
          if (o_beat.last) begin
            state_nxt = ccfr_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ccfr_pkg::S_PRD;
          end
        end
      end
      default: begin
        state_nxt = ccfr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ccfr_pkg::S_IDLE;
      count_r    <= '0;
      in_frame_r <= 1'b0;
      held_r     <= 1'b0;
      conn_r     <= 1'b0;
      rv_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      in_frame_r <= in_frame_nxt;
      held_r     <= held_nxt;
      rv_r       <= rv_nxt;
      if (cfg_wr_en) begin
        conn_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ack_r   <= ack_nxt;
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    prev2_r <= prev2_nxt;
    chk_r   <= chk_nxt;
    sum_r   <= sum_nxt;
  end

  a_held_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_r) |-> ($past(state_r) == ccfr_pkg::S_CHECK ||
                       $past(state_r) == ccfr_pkg::S_ACK))
    else $error("payload hold set outside frame completion");

  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_valid && in_ready && mem_waddr != LAST_IDX))
    else $error("store written without an accepted beat");

  a_pay_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccfr_pkg::S_PWR) |-> (idx_r < len_r))
    else $error("payload index beyond frame");

  a_sum_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccfr_pkg::S_SUM && $past(state_r) == ccfr_pkg::S_IDLE)
      |-> (len_r != '0))
    else $error("empty payload entered checksum pass");

endmodule
`default_nettype wire
